// ===== rtl/core/rvx_pkg.sv =====
// Shared types, operation codes and helpers for the RV64IA execute pipeline.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package rvx_pkg;

    // Operation codes, dense from 0; anything above the last AMO is not implemented
    localparam logic [6:0] F_LB        = 7'd0;
    localparam logic [6:0] F_LBU       = 7'd1;
    localparam logic [6:0] F_LH        = 7'd2;
    localparam logic [6:0] F_LHU       = 7'd3;
    localparam logic [6:0] F_LW        = 7'd4;
    localparam logic [6:0] F_LWU       = 7'd5;
    localparam logic [6:0] F_LD        = 7'd6;
    localparam logic [6:0] F_SB        = 7'd7;
    localparam logic [6:0] F_SH        = 7'd8;
    localparam logic [6:0] F_SW        = 7'd9;
    localparam logic [6:0] F_SD        = 7'd10;
    localparam logic [6:0] F_SLL       = 7'd11;
    localparam logic [6:0] F_SLLI      = 7'd12;
    localparam logic [6:0] F_SLLW      = 7'd13;
    localparam logic [6:0] F_SLLIW     = 7'd14;
    localparam logic [6:0] F_SRL       = 7'd15;
    localparam logic [6:0] F_SRLI      = 7'd16;
    localparam logic [6:0] F_SRLW      = 7'd17;
    localparam logic [6:0] F_SRLIW     = 7'd18;
    localparam logic [6:0] F_SRA       = 7'd19;
    localparam logic [6:0] F_SRAI      = 7'd20;
    localparam logic [6:0] F_SRAW      = 7'd21;
    localparam logic [6:0] F_SRAIW     = 7'd22;
    localparam logic [6:0] F_ADD       = 7'd23;
    localparam logic [6:0] F_ADDW      = 7'd24;
    localparam logic [6:0] F_ADDI      = 7'd25;
    localparam logic [6:0] F_ADDIW     = 7'd26;
    localparam logic [6:0] F_SUB       = 7'd27;
    localparam logic [6:0] F_SUBW      = 7'd28;
    localparam logic [6:0] F_LUI       = 7'd29;
    localparam logic [6:0] F_AUIPC     = 7'd30;
    localparam logic [6:0] F_XOR       = 7'd31;
    localparam logic [6:0] F_XORI      = 7'd32;
    localparam logic [6:0] F_OR        = 7'd33;
    localparam logic [6:0] F_ORI       = 7'd34;
    localparam logic [6:0] F_AND       = 7'd35;
    localparam logic [6:0] F_ANDI      = 7'd36;
    localparam logic [6:0] F_SLT       = 7'd37;
    localparam logic [6:0] F_SLTU      = 7'd38;
    localparam logic [6:0] F_SLTI      = 7'd39;
    localparam logic [6:0] F_SLTIU     = 7'd40;
    localparam logic [6:0] F_BEQ       = 7'd41;
    localparam logic [6:0] F_BNE       = 7'd42;
    localparam logic [6:0] F_BLT       = 7'd43;
    localparam logic [6:0] F_BLTU      = 7'd44;
    localparam logic [6:0] F_BGE       = 7'd45;
    localparam logic [6:0] F_BGEU      = 7'd46;
    localparam logic [6:0] F_JAL       = 7'd47;
    localparam logic [6:0] F_JALR      = 7'd48;
    localparam logic [6:0] F_ECALL     = 7'd49;
    localparam logic [6:0] F_FENCE     = 7'd50;
    localparam logic [6:0] F_LR_W      = 7'd51;
    localparam logic [6:0] F_LR_D      = 7'd52;
    localparam logic [6:0] F_SC        = 7'd53;
    localparam logic [6:0] F_AMOSWAP_W = 7'd54;
    localparam logic [6:0] F_AMOSWAP_D = 7'd55;
    localparam logic [6:0] F_AMOADD_W  = 7'd56;
    localparam logic [6:0] F_AMOADD_D  = 7'd57;
    localparam logic [6:0] F_AMOAND_W  = 7'd58;
    localparam logic [6:0] F_AMOAND_D  = 7'd59;
    localparam logic [6:0] F_AMOOR_W   = 7'd60;
    localparam logic [6:0] F_AMOOR_D   = 7'd61;
    localparam logic [6:0] F_AMOXOR_W  = 7'd62;
    localparam logic [6:0] F_AMOXOR_D  = 7'd63;
    localparam logic [6:0] F_AMOMIN_W  = 7'd64;
    localparam logic [6:0] F_AMOMIN_D  = 7'd65;
    localparam logic [6:0] F_AMOMINU_W = 7'd66;
    localparam logic [6:0] F_AMOMINU_D = 7'd67;
    localparam logic [6:0] F_AMOMAX_W  = 7'd68;
    localparam logic [6:0] F_AMOMAX_D  = 7'd69;
    localparam logic [6:0] F_AMOMAXU_W = 7'd70;
    localparam logic [6:0] F_AMOMAXU_D = 7'd71;

    // Link offset for JAL and JALR, and fall-through for branches
    localparam logic [63:0] INSN_BYTES = 64'd4;

    typedef enum logic [2:0] {
        RES_ZERO  = 3'd0,
        RES_ADD   = 3'd1,
        RES_SHIFT = 3'd2,
        RES_LOGIC = 3'd3,
        RES_SLT   = 3'd4,
        RES_LOAD  = 3'd5,
        RES_PCOFF = 3'd6,
        RES_LINK  = 3'd7
    } t_res_sel;

    typedef enum logic [1:0] {
        SH_LL = 2'd0,
        SH_RL = 2'd1,
        SH_RA = 2'd2
    } t_shift_op;

    typedef enum logic [1:0] {
        LG_XOR = 2'd0,
        LG_OR  = 2'd1,
        LG_AND = 2'd2
    } t_logic_op;

    typedef enum logic [2:0] {
        LD_B  = 3'd0,
        LD_BU = 3'd1,
        LD_H  = 3'd2,
        LD_HU = 3'd3,
        LD_W  = 3'd4,
        LD_WU = 3'd5,
        LD_D  = 3'd6
    } t_load_op;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_A    = 2'd1,
        WR_AMO  = 2'd2
    } t_wr_sel;

    typedef enum logic [3:0] {
        AMO_SWAP = 4'd0,
        AMO_ADD  = 4'd1,
        AMO_AND  = 4'd2,
        AMO_OR   = 4'd3,
        AMO_XOR  = 4'd4,
        AMO_MIN  = 4'd5,
        AMO_MINU = 4'd6,
        AMO_MAX  = 4'd7,
        AMO_MAXU = 4'd8
    } t_amo_op;

    typedef enum logic [3:0] {
        BR_NONE = 4'd0,
        BR_BEQ  = 4'd1,
        BR_BNE  = 4'd2,
        BR_BLT  = 4'd3,
        BR_BLTU = 4'd4,
        BR_BGE  = 4'd5,
        BR_BGEU = 4'd6,
        BR_JAL  = 4'd7,
        BR_JALR = 4'd8
    } t_br_op;

    typedef enum logic [1:0] {
        EXC_NONE  = 2'd0,
        EXC_ECALL = 2'd1,
        EXC_NOIMP = 2'd2
    } t_exc;

    // Decoded control that travels with an item down the pipeline
    typedef struct packed {
        t_res_sel  res_sel;
        logic      word_res;
        logic      sub;
        logic      zero_a;
        t_shift_op sh_op;
        t_logic_op lg_op;
        logic      cmp_unsigned;
        t_load_op  ld_op;
        t_wr_sel   wr_sel;
        t_amo_op   amo_op;
        logic      amo_word;
        t_br_op    br_op;
        t_exc      exc;
    } t_ctrl;

    // Decode stage to execute stage
    typedef struct packed {
        t_ctrl       ctrl;
        logic [63:0] a;
        logic [63:0] b_op;
        logic [63:0] pc;
        logic [63:0] pc_off;
        logic [63:0] md;
        logic [63:0] sh_src;
        logic [5:0]  shamt;
        logic [63:0] amo_x;
        logic [63:0] amo_y;
    } t_s1;

    // Execute stage to writeback stage
    typedef struct packed {
        t_ctrl       ctrl;
        logic [63:0] a;
        logic [63:0] add_res;
        logic [63:0] sh_res;
        logic [63:0] lg_res;
        logic        slt;
        logic [63:0] ld_res;
        logic [63:0] amo_wr;
        logic [63:0] pc_sum;
        logic [63:0] pc_next;
        logic        taken;
    } t_s2;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

// ===== rtl/core/rvx_decode.sv =====
// Decode stage: turns the operation code into control, picks operands.
// Depends on rvx_pkg.
`timescale 1ns / 1ps

module rvx_decode
    import rvx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [6:0]         i_func,
    input  logic [63:0]        i_operand_a,
    input  logic [63:0]        i_operand_b,
    input  logic signed [31:0] i_immediate,
    input  logic [63:0]        i_pc,
    input  logic [63:0]        i_mem_data,
    output logic               o_valid,
    output t_s1                o_s1
);

    typedef enum logic [1:0] {
        BSEL_REG   = 2'd0,
        BSEL_IMM   = 2'd1,
        BSEL_UPPER = 2'd2
    } t_bsel;

    t_ctrl       c;
    t_bsel       bsel;
    logic        sh_word;
    logic        pc_upper;
    logic [63:0] imm64;
    logic [63:0] upper64;
    logic [63:0] b_op;
    logic        amo_signed;
    t_s1         n_s1;
    logic        r_valid;
    t_s1         r_s1;

    // Decode operation code into control fields
    always_comb begin
        c        = '0;
        bsel     = BSEL_REG;
        sh_word  = 1'b0;
        pc_upper = 1'b0;
        unique case (i_func) inside
            F_LB: begin c.res_sel = RES_LOAD; c.ld_op = LD_B; end
            F_LBU: begin c.res_sel = RES_LOAD; c.ld_op = LD_BU; end
            F_LH: begin c.res_sel = RES_LOAD; c.ld_op = LD_H; end
            F_LHU: begin c.res_sel = RES_LOAD; c.ld_op = LD_HU; end
            F_LW, F_LR_W: begin c.res_sel = RES_LOAD; c.ld_op = LD_W; end
            F_LWU: begin c.res_sel = RES_LOAD; c.ld_op = LD_WU; end
            F_LD, F_LR_D: begin c.res_sel = RES_LOAD; c.ld_op = LD_D; end
            F_SB, F_SH, F_SW, F_SD, F_SC: begin
                c.wr_sel = WR_A;
            end
            F_SLL: begin c.res_sel = RES_SHIFT; c.sh_op = SH_LL; end
            F_SLLI: begin c.res_sel = RES_SHIFT; c.sh_op = SH_LL; bsel = BSEL_IMM; end
            F_SLLW: begin
                c.res_sel = RES_SHIFT; c.sh_op = SH_LL; c.word_res = 1'b1; sh_word = 1'b1;
            end
            F_SLLIW: begin
                c.res_sel = RES_SHIFT; c.sh_op = SH_LL; c.word_res = 1'b1; sh_word = 1'b1;
                bsel = BSEL_IMM;
            end
            F_SRL: begin c.res_sel = RES_SHIFT; c.sh_op = SH_RL; end
            F_SRLI: begin c.res_sel = RES_SHIFT; c.sh_op = SH_RL; bsel = BSEL_IMM; end
            F_SRLW: begin
                c.res_sel = RES_SHIFT; c.sh_op = SH_RL; c.word_res = 1'b1; sh_word = 1'b1;
            end
            F_SRLIW: begin
                c.res_sel = RES_SHIFT; c.sh_op = SH_RL; c.word_res = 1'b1; sh_word = 1'b1;
                bsel = BSEL_IMM;
            end
            F_SRA: begin c.res_sel = RES_SHIFT; c.sh_op = SH_RA; end
            F_SRAI: begin c.res_sel = RES_SHIFT; c.sh_op = SH_RA; bsel = BSEL_IMM; end
            F_SRAW: begin
                c.res_sel = RES_SHIFT; c.sh_op = SH_RA; c.word_res = 1'b1; sh_word = 1'b1;
            end
            F_SRAIW: begin
                c.res_sel = RES_SHIFT; c.sh_op = SH_RA; c.word_res = 1'b1; sh_word = 1'b1;
                bsel = BSEL_IMM;
            end
            F_ADD: c.res_sel = RES_ADD;
            F_ADDW: begin c.res_sel = RES_ADD; c.word_res = 1'b1; end
            F_ADDI: begin c.res_sel = RES_ADD; bsel = BSEL_IMM; end
            F_ADDIW: begin c.res_sel = RES_ADD; c.word_res = 1'b1; bsel = BSEL_IMM; end
            F_SUB: begin c.res_sel = RES_ADD; c.sub = 1'b1; end
            F_SUBW: begin c.res_sel = RES_ADD; c.sub = 1'b1; c.word_res = 1'b1; end
            F_LUI: begin c.res_sel = RES_ADD; c.zero_a = 1'b1; bsel = BSEL_UPPER; end
            F_AUIPC: begin c.res_sel = RES_PCOFF; pc_upper = 1'b1; end
            F_XOR: begin c.res_sel = RES_LOGIC; c.lg_op = LG_XOR; end
            F_XORI: begin c.res_sel = RES_LOGIC; c.lg_op = LG_XOR; bsel = BSEL_IMM; end
            F_OR: begin c.res_sel = RES_LOGIC; c.lg_op = LG_OR; end
            F_ORI: begin c.res_sel = RES_LOGIC; c.lg_op = LG_OR; bsel = BSEL_IMM; end
            F_AND: begin c.res_sel = RES_LOGIC; c.lg_op = LG_AND; end
            F_ANDI: begin c.res_sel = RES_LOGIC; c.lg_op = LG_AND; bsel = BSEL_IMM; end
            F_SLT: c.res_sel = RES_SLT;
            F_SLTU: begin c.res_sel = RES_SLT; c.cmp_unsigned = 1'b1; end
            F_SLTI: begin c.res_sel = RES_SLT; bsel = BSEL_IMM; end
            F_SLTIU: begin c.res_sel = RES_SLT; c.cmp_unsigned = 1'b1; bsel = BSEL_IMM; end
            F_BEQ: c.br_op = BR_BEQ;
            F_BNE: c.br_op = BR_BNE;
            F_BLT: c.br_op = BR_BLT;
            F_BLTU: c.br_op = BR_BLTU;
            F_BGE: c.br_op = BR_BGE;
            F_BGEU: c.br_op = BR_BGEU;
            F_JAL: begin c.br_op = BR_JAL; c.res_sel = RES_LINK; end
            F_JALR: begin c.br_op = BR_JALR; c.res_sel = RES_LINK; bsel = BSEL_IMM; end
            F_ECALL: c.exc = EXC_ECALL;
            F_FENCE: c.exc = EXC_NONE;
            F_AMOSWAP_W, F_AMOSWAP_D, F_AMOADD_W, F_AMOADD_D, F_AMOAND_W, F_AMOAND_D,
            F_AMOOR_W, F_AMOOR_D, F_AMOXOR_W, F_AMOXOR_D, F_AMOMIN_W, F_AMOMIN_D,
            F_AMOMINU_W, F_AMOMINU_D, F_AMOMAX_W, F_AMOMAX_D, F_AMOMAXU_W,
            F_AMOMAXU_D: begin
                // Word forms have even codes in this range
                c.res_sel  = RES_LOAD;
                c.wr_sel   = WR_AMO;
                c.amo_word = ~i_func[0];
                c.ld_op    = i_func[0] ? LD_D : LD_W;
                unique case (i_func) inside
                    F_AMOSWAP_W, F_AMOSWAP_D: c.amo_op = AMO_SWAP;
                    F_AMOADD_W, F_AMOADD_D:   c.amo_op = AMO_ADD;
                    F_AMOAND_W, F_AMOAND_D:   c.amo_op = AMO_AND;
                    F_AMOOR_W, F_AMOOR_D:     c.amo_op = AMO_OR;
                    F_AMOXOR_W, F_AMOXOR_D:   c.amo_op = AMO_XOR;
                    F_AMOMIN_W, F_AMOMIN_D:   c.amo_op = AMO_MIN;
                    F_AMOMINU_W, F_AMOMINU_D: c.amo_op = AMO_MINU;
                    F_AMOMAX_W, F_AMOMAX_D:   c.amo_op = AMO_MAX;
                    default:                  c.amo_op = AMO_MAXU;
                endcase
            end
            default: c.exc = EXC_NOIMP;
        endcase
    end

    // Build operands for the execute stage
    always_comb begin
        imm64   = sext32(i_immediate);
        upper64 = sext32({i_immediate[19:0], 12'd0});
        case (bsel)
            BSEL_IMM:   b_op = imm64;
            BSEL_UPPER: b_op = upper64;
            default:    b_op = i_operand_b;
        endcase

        n_s1.ctrl   = c;
        n_s1.a      = i_operand_a;
        n_s1.b_op   = b_op;
        n_s1.pc     = i_pc;
        n_s1.pc_off = pc_upper ? upper64 : imm64;
        n_s1.md     = i_mem_data;

        // Word shifts see only the low word, extended the way the shift needs
        if (sh_word) begin
            n_s1.sh_src = (c.sh_op == SH_RA) ? sext32(i_operand_a[31:0])
                                             : {32'd0, i_operand_a[31:0]};
            n_s1.shamt  = {1'b0, b_op[4:0]};
        end else begin
            n_s1.sh_src = i_operand_a;
            n_s1.shamt  = b_op[5:0];
        end

        // Word AMOs: sign-extend for signed compares, zero-extend otherwise
        amo_signed = (c.amo_op == AMO_MIN) || (c.amo_op == AMO_MAX);
        if (c.amo_word && amo_signed) begin
            n_s1.amo_x = sext32(i_mem_data[31:0]);
            n_s1.amo_y = sext32(i_operand_a[31:0]);
        end else if (c.amo_word) begin
            n_s1.amo_x = {32'd0, i_mem_data[31:0]};
            n_s1.amo_y = {32'd0, i_operand_a[31:0]};
        end else begin
            n_s1.amo_x = i_mem_data;
            n_s1.amo_y = i_operand_a;
        end
    end

    // Advance valid with reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ===== rtl/core/rvx_alu.sv =====
// Execute stage: adder, shifter, logic, compares, load extend, AMO update.
// Depends on rvx_pkg.
`timescale 1ns / 1ps

module rvx_alu
    import rvx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_s1  i_s1,
    output logic o_valid,
    output t_s2  o_s2
);

    logic [63:0] add_a;
    logic [63:0] add_b;
    logic        eq;
    logic        lts;
    logic        ltu;
    logic        amo_lt;
    logic        amo_signed;
    t_s2         n_s2;
    logic        r_valid;
    t_s2         r_s2;

    always_comb begin
        n_s2.ctrl = i_s1.ctrl;
        n_s2.a    = i_s1.a;

        // Add or subtract; LUI zeroes the first operand
        add_a        = i_s1.ctrl.zero_a ? 64'd0 : i_s1.a;
        add_b        = i_s1.ctrl.sub ? ~i_s1.b_op : i_s1.b_op;
        n_s2.add_res = add_a + add_b + {63'd0, i_s1.ctrl.sub};

        // Barrel shift
        case (i_s1.ctrl.sh_op)
            SH_RL:   n_s2.sh_res = i_s1.sh_src >> i_s1.shamt;
            SH_RA:   n_s2.sh_res = 64'($signed(i_s1.sh_src) >>> i_s1.shamt);
            default: n_s2.sh_res = i_s1.sh_src << i_s1.shamt;
        endcase

        case (i_s1.ctrl.lg_op)
            LG_OR:   n_s2.lg_res = i_s1.a | i_s1.b_op;
            LG_AND:  n_s2.lg_res = i_s1.a & i_s1.b_op;
            default: n_s2.lg_res = i_s1.a ^ i_s1.b_op;
        endcase

        // Shared compare for set-less-than and branches
        eq       = (i_s1.a == i_s1.b_op);
        lts      = ($signed(i_s1.a) < $signed(i_s1.b_op));
        ltu      = (i_s1.a < i_s1.b_op);
        n_s2.slt = i_s1.ctrl.cmp_unsigned ? ltu : lts;

        case (i_s1.ctrl.br_op)
            BR_BEQ:           n_s2.taken = eq;
            BR_BNE:           n_s2.taken = ~eq;
            BR_BLT:           n_s2.taken = lts;
            BR_BLTU:          n_s2.taken = ltu;
            BR_BGE:           n_s2.taken = ~lts;
            BR_BGEU:          n_s2.taken = ~ltu;
            BR_JAL, BR_JALR:  n_s2.taken = 1'b1;
            default:          n_s2.taken = 1'b0;
        endcase

        // Extend loaded data
        case (i_s1.ctrl.ld_op)
            LD_B:    n_s2.ld_res = {{56{i_s1.md[7]}}, i_s1.md[7:0]};
            LD_BU:   n_s2.ld_res = {56'd0, i_s1.md[7:0]};
            LD_H:    n_s2.ld_res = {{48{i_s1.md[15]}}, i_s1.md[15:0]};
            LD_HU:   n_s2.ld_res = {48'd0, i_s1.md[15:0]};
            LD_W:    n_s2.ld_res = sext32(i_s1.md[31:0]);
            LD_WU:   n_s2.ld_res = {32'd0, i_s1.md[31:0]};
            default: n_s2.ld_res = i_s1.md;
        endcase

        // Atomic read-modify-write value
        amo_signed = (i_s1.ctrl.amo_op == AMO_MIN) || (i_s1.ctrl.amo_op == AMO_MAX);
        amo_lt     = amo_signed ? ($signed(i_s1.amo_x) < $signed(i_s1.amo_y))
                                : (i_s1.amo_x < i_s1.amo_y);
        case (i_s1.ctrl.amo_op)
            AMO_ADD:            n_s2.amo_wr = i_s1.amo_x + i_s1.amo_y;
            AMO_AND:            n_s2.amo_wr = i_s1.amo_x & i_s1.amo_y;
            AMO_OR:             n_s2.amo_wr = i_s1.amo_x | i_s1.amo_y;
            AMO_XOR:            n_s2.amo_wr = i_s1.amo_x ^ i_s1.amo_y;
            AMO_MIN, AMO_MINU:  n_s2.amo_wr = amo_lt ? i_s1.amo_x : i_s1.amo_y;
            AMO_MAX, AMO_MAXU:  n_s2.amo_wr = amo_lt ? i_s1.amo_y : i_s1.amo_x;
            default:            n_s2.amo_wr = i_s1.amo_y;
        endcase

        // Address adders
        n_s2.pc_sum  = i_s1.pc + i_s1.pc_off;
        n_s2.pc_next = i_s1.pc + INSN_BYTES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

// ===== rtl/core/rvx_writeback.sv =====
// Writeback stage: selects and formats the result fields into output registers.
// Depends on rvx_pkg.
`timescale 1ns / 1ps

module rvx_writeback
    import rvx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_s2         i_s2,
    output logic        o_done,
    output logic [63:0] o_result,
    output logic [63:0] o_mem_write_data,
    output logic [63:0] o_branch_target,
    output logic        o_branch_taken,
    output logic [1:0]  o_exception
);

    logic [63:0] res_raw;
    logic [63:0] n_result;
    logic [63:0] n_wdata;
    logic [63:0] n_target;
    logic        r_done;
    logic [63:0] r_result;
    logic [63:0] r_wdata;
    logic [63:0] r_target;
    logic        r_taken;
    logic [1:0]  r_exc;

    always_comb begin
        // Pick destination value, then fold word forms
        case (i_s2.ctrl.res_sel)
            RES_ADD:   res_raw = i_s2.add_res;
            RES_SHIFT: res_raw = i_s2.sh_res;
            RES_LOGIC: res_raw = i_s2.lg_res;
            RES_SLT:   res_raw = {63'd0, i_s2.slt};
            RES_LOAD:  res_raw = i_s2.ld_res;
            RES_PCOFF: res_raw = i_s2.pc_sum;
            RES_LINK:  res_raw = i_s2.pc_next;
            default:   res_raw = 64'd0;
        endcase
        n_result = i_s2.ctrl.word_res ? sext32(res_raw[31:0]) : res_raw;

        case (i_s2.ctrl.wr_sel)
            WR_A:    n_wdata = i_s2.a;
            WR_AMO:  n_wdata = i_s2.ctrl.amo_word ? {32'd0, i_s2.amo_wr[31:0]} : i_s2.amo_wr;
            default: n_wdata = 64'd0;
        endcase

        // Jump register clears bit 0; not-taken branches fall through
        case (i_s2.ctrl.br_op)
            BR_NONE: n_target = 64'd0;
            BR_JALR: n_target = {i_s2.add_res[63:1], 1'b0};
            BR_JAL:  n_target = i_s2.pc_sum;
            default: n_target = i_s2.taken ? i_s2.pc_sum : i_s2.pc_next;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_wdata  <= n_wdata;
        r_target <= n_target;
        r_taken  <= i_s2.taken;
        r_exc    <= i_s2.ctrl.exc;
    end

    assign o_done           = r_done;
    assign o_result         = r_result;
    assign o_mem_write_data = r_wdata;
    assign o_branch_target  = r_target;
    assign o_branch_taken   = r_taken;
    assign o_exception      = r_exc;

endmodule

// ===== rtl/core/rv64ia_execute_unit_core.sv =====
// Top level of the RV64IA execute pipeline: decode, execute, writeback.
// Depends on rvx_pkg, rvx_decode, rvx_alu, rvx_writeback.
`timescale 1ns / 1ps

// RV64I plus atomics execute unit.
// Input channel: drive the decoded instruction on i_func, i_operand_a,
// i_operand_b, i_immediate, i_pc and i_mem_data with start high; the item
// is taken at a rising edge where start is high and busy is low.
// Output channel: o_done pulses for one cycle with o_result,
// o_mem_write_data, o_branch_target, o_branch_taken and o_exception.
// The receiver cannot hold results off and none is needed: the pipe never
// stalls.
// Path: an accepted item passes the decode register, the execute register and the
// output register, whose valid bit drives o_done.
// Throughput: one item per cycle while busy is low; the deepest stage is the 64-bit
// adder, the barrel shifter and the compares of the execute register.
// Reset (synchronous, active low) drops every item in flight; busy is registered,
// set while reset is asserted and cleared at a clock edge once reset is released.

module rv64ia_execute_unit_core
    import rvx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [6:0]         i_func,
    input  logic [63:0]        i_operand_a,
    input  logic [63:0]        i_operand_b,
    input  logic signed [31:0] i_immediate,
    input  logic [63:0]        i_pc,
    input  logic [63:0]        i_mem_data,
    output logic               o_done,
    output logic [63:0]        o_result,
    output logic [63:0]        o_mem_write_data,
    output logic [63:0]        o_branch_target,
    output logic               o_branch_taken,
    output logic [1:0]         o_exception
);

    logic r_busy;
    logic accept;
    logic s1_valid;
    t_s1  s1;
    logic s2_valid;
    t_s2  s2;

    // Hold off items until reset has been released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start & ~r_busy;

    rvx_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_func      (i_func),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_immediate (i_immediate),
        .i_pc        (i_pc),
        .i_mem_data  (i_mem_data),
        .o_valid     (s1_valid),
        .o_s1        (s1)
    );

    rvx_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    rvx_writeback u_writeback (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s2_valid),
        .i_s2             (s2),
        .o_done           (o_done),
        .o_result         (o_result),
        .o_mem_write_data (o_mem_write_data),
        .o_branch_target  (o_branch_target),
        .o_branch_taken   (o_branch_taken),
        .o_exception      (o_exception)
    );

    // Every accepted item comes out with an o_done strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("accepted item did not complete after three cycles");

    // Nothing comes out that was not accepted
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 3))
        else $error("result strobe without an accepted item");

    // Unknown codes give only the exception
    a_noimp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_exception == EXC_NOIMP) |->
            (o_result == 64'd0 && o_mem_write_data == 64'd0 &&
             o_branch_target == 64'd0 && !o_branch_taken))
        else $error("not-implemented item drove result fields");

    // Reset empties the pipe
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && busy))
        else $error("pipe not flushed by reset");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for rv64ia_execute_unit_core: directed corner cases, a sweep of
// every operation code and random instructions, each checked against an in-bench predictor.
// Depends on rvx_pkg for the operation codes and exception codes.
`timescale 1ns / 1ps

module testbench;
    import rvx_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 12;
    localparam int PIPE_DEPTH  = 3;
    localparam int STALL_LIMIT = 200;
    localparam int RANDOM_LEN  = 420;

    // One decoded instruction as driven on the input ports
    typedef struct {
        logic [6:0]         func;
        logic [63:0]        a;
        logic [63:0]        b;
        logic signed [31:0] imm;
        logic [63:0]        pc;
        logic [63:0]        md;
    } t_insn;

    // Predicted execute outcome, with the instruction that caused it
    typedef struct {
        t_insn       insn;
        logic [63:0] result;
        logic [63:0] wr_data;
        logic [63:0] target;
        logic        taken;
        t_exc        exc;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [6:0]         i_func = '0;
    logic [63:0]        i_operand_a = '0;
    logic [63:0]        i_operand_b = '0;
    logic signed [31:0] i_immediate = '0;
    logic [63:0]        i_pc = '0;
    logic [63:0]        i_mem_data = '0;
    logic               o_done;
    logic [63:0]        o_result;
    logic [63:0]        o_mem_write_data;
    logic [63:0]        o_branch_target;
    logic               o_branch_taken;
    logic [1:0]         o_exception;

    t_outcome pending_q[$];
    int       errors = 0;
    int       idle_cycles = 0;
    logic     back_to_back = 1'b0;

    rv64ia_execute_unit_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .i_immediate      (i_immediate),
        .i_pc             (i_pc),
        .i_mem_data       (i_mem_data),
        .o_done           (o_done),
        .o_result         (o_result),
        .o_mem_write_data (o_mem_write_data),
        .o_branch_target  (o_branch_target),
        .o_branch_taken   (o_branch_taken),
        .o_exception      (o_exception)
    );

    // Run the clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_insn make_insn(input logic [6:0] func, input logic [63:0] a,
                                        input logic [63:0] b, input logic signed [31:0] imm,
                                        input logic [63:0] pc, input logic [63:0] md);
        t_insn x;
        x.func = func;
        x.a    = a;
        x.b    = b;
        x.imm  = imm;
        x.pc   = pc;
        x.md   = md;
        return x;
    endfunction

    // Work out what the execute stage must produce for one instruction
    function automatic t_outcome execute_insn(input t_insn x);
        t_outcome    r;
        logic [63:0] imm64;
        logic [63:0] upper;
        logic [63:0] mword;
        logic [63:0] sum;
        logic [31:0] w;
        logic        has_cond;
        logic        cond;
        imm64    = {{32{x.imm[31]}}, x.imm};
        upper    = {{32{x.imm[19]}}, x.imm[19:0], 12'd0};
        mword    = {{32{x.md[31]}}, x.md[31:0]};
        r.insn    = x;
        r.result  = '0;
        r.wr_data = '0;
        r.target  = '0;
        r.taken   = 1'b0;
        r.exc     = EXC_NONE;
        has_cond  = 1'b0;
        cond      = 1'b0;
        case (x.func)
            F_LB:  r.result = {{56{x.md[7]}}, x.md[7:0]};
            F_LBU: r.result = {56'd0, x.md[7:0]};
            F_LH:  r.result = {{48{x.md[15]}}, x.md[15:0]};
            F_LHU: r.result = {48'd0, x.md[15:0]};
            F_LW:  r.result = mword;
            F_LWU: r.result = {32'd0, x.md[31:0]};
            F_LD:  r.result = x.md;
            F_SB, F_SH, F_SW, F_SD: r.wr_data = x.a;
            F_SLL:  r.result = x.a << x.b[5:0];
            F_SLLI: r.result = x.a << imm64[5:0];
            F_SLLW: begin
                w = x.a[31:0] << x.b[4:0];
                r.result = {{32{w[31]}}, w};
            end
            F_SLLIW: begin
                w = x.a[31:0] << imm64[4:0];
                r.result = {{32{w[31]}}, w};
            end
            F_SRL:  r.result = x.a >> x.b[5:0];
            F_SRLI: r.result = x.a >> imm64[5:0];
            F_SRLW: begin
                w = x.a[31:0] >> x.b[4:0];
                r.result = {{32{w[31]}}, w};
            end
            F_SRLIW: begin
                w = x.a[31:0] >> imm64[4:0];
                r.result = {{32{w[31]}}, w};
            end
            F_SRA:  r.result = $signed(x.a) >>> x.b[5:0];
            F_SRAI: r.result = $signed(x.a) >>> imm64[5:0];
            F_SRAW: begin
                w = $signed(x.a[31:0]) >>> x.b[4:0];
                r.result = {{32{w[31]}}, w};
            end
            F_SRAIW: begin
                w = $signed(x.a[31:0]) >>> imm64[4:0];
                r.result = {{32{w[31]}}, w};
            end
            F_ADD: r.result = x.a + x.b;
            F_ADDW: begin
                sum = x.a + x.b;
                r.result = {{32{sum[31]}}, sum[31:0]};
            end
            F_ADDI: r.result = x.a + imm64;
            F_ADDIW: begin
                sum = x.a + imm64;
                r.result = {{32{sum[31]}}, sum[31:0]};
            end
            F_SUB: r.result = x.a - x.b;
            F_SUBW: begin
                sum = x.a - x.b;
                r.result = {{32{sum[31]}}, sum[31:0]};
            end
            F_LUI:   r.result = upper;
            F_AUIPC: r.result = x.pc + upper;
            F_XOR:   r.result = x.a ^ x.b;
            F_XORI:  r.result = x.a ^ imm64;
            F_OR:    r.result = x.a | x.b;
            F_ORI:   r.result = x.a | imm64;
            F_AND:   r.result = x.a & x.b;
            F_ANDI:  r.result = x.a & imm64;
            F_SLT:   r.result = {63'd0, $signed(x.a) < $signed(x.b)};
            F_SLTU:  r.result = {63'd0, x.a < x.b};
            F_SLTI:  r.result = {63'd0, $signed(x.a) < $signed(imm64)};
            F_SLTIU: r.result = {63'd0, x.a < imm64};
            F_BEQ: begin
                has_cond = 1'b1;
                cond = (x.a == x.b);
            end
            F_BNE: begin
                has_cond = 1'b1;
                cond = (x.a != x.b);
            end
            F_BLT: begin
                has_cond = 1'b1;
                cond = ($signed(x.a) < $signed(x.b));
            end
            F_BLTU: begin
                has_cond = 1'b1;
                cond = (x.a < x.b);
            end
            F_BGE: begin
                has_cond = 1'b1;
                cond = !($signed(x.a) < $signed(x.b));
            end
            F_BGEU: begin
                has_cond = 1'b1;
                cond = (x.a >= x.b);
            end
            F_JAL: begin
                r.target = x.pc + imm64;
                r.taken  = 1'b1;
                r.result = x.pc + INSN_BYTES;
            end
            F_JALR: begin
                sum = x.a + imm64;
                r.target = {sum[63:1], 1'b0};
                r.taken  = 1'b1;
                r.result = x.pc + INSN_BYTES;
            end
            F_ECALL: r.exc = EXC_ECALL;
            F_FENCE: ;
            F_LR_W: r.result = mword;
            F_LR_D: r.result = x.md;
            F_SC:   r.wr_data = x.a;
            F_AMOSWAP_W: begin
                r.result  = mword;
                r.wr_data = {32'd0, x.a[31:0]};
            end
            F_AMOSWAP_D: begin
                r.result  = x.md;
                r.wr_data = x.a;
            end
            F_AMOADD_W: begin
                w = x.md[31:0] + x.a[31:0];
                r.result  = mword;
                r.wr_data = {32'd0, w};
            end
            F_AMOADD_D: begin
                r.result  = x.md;
                r.wr_data = x.md + x.a;
            end
            F_AMOAND_W: begin
                r.result  = mword;
                r.wr_data = {32'd0, x.md[31:0] & x.a[31:0]};
            end
            F_AMOAND_D: begin
                r.result  = x.md;
                r.wr_data = x.md & x.a;
            end
            F_AMOOR_W: begin
                r.result  = mword;
                r.wr_data = {32'd0, x.md[31:0] | x.a[31:0]};
            end
            F_AMOOR_D: begin
                r.result  = x.md;
                r.wr_data = x.md | x.a;
            end
            F_AMOXOR_W: begin
                r.result  = mword;
                r.wr_data = {32'd0, x.md[31:0] ^ x.a[31:0]};
            end
            F_AMOXOR_D: begin
                r.result  = x.md;
                r.wr_data = x.md ^ x.a;
            end
            F_AMOMIN_W: begin
                w = ($signed(x.md[31:0]) < $signed(x.a[31:0])) ? x.md[31:0] : x.a[31:0];
                r.result  = mword;
                r.wr_data = {32'd0, w};
            end
            F_AMOMIN_D: begin
                r.result  = x.md;
                r.wr_data = ($signed(x.md) < $signed(x.a)) ? x.md : x.a;
            end
            F_AMOMINU_W: begin
                w = (x.md[31:0] < x.a[31:0]) ? x.md[31:0] : x.a[31:0];
                r.result  = mword;
                r.wr_data = {32'd0, w};
            end
            F_AMOMINU_D: begin
                r.result  = x.md;
                r.wr_data = (x.md < x.a) ? x.md : x.a;
            end
            F_AMOMAX_W: begin
                w = ($signed(x.md[31:0]) < $signed(x.a[31:0])) ? x.a[31:0] : x.md[31:0];
                r.result  = mword;
                r.wr_data = {32'd0, w};
            end
            F_AMOMAX_D: begin
                r.result  = x.md;
                r.wr_data = ($signed(x.md) < $signed(x.a)) ? x.a : x.md;
            end
            F_AMOMAXU_W: begin
                w = (x.md[31:0] < x.a[31:0]) ? x.a[31:0] : x.md[31:0];
                r.result  = mword;
                r.wr_data = {32'd0, w};
            end
            F_AMOMAXU_D: begin
                r.result  = x.md;
                r.wr_data = (x.md < x.a) ? x.a : x.md;
            end
            default: r.exc = EXC_NOIMP;
        endcase
        // Resolve conditional branches: taken goes to pc+imm, else fall through
        if (has_cond) begin
            if (cond) begin
                r.target = x.pc + imm64;
                r.taken  = 1'b1;
            end else begin
                r.target = x.pc + INSN_BYTES;
            end
        end
        return r;
    endfunction

    // Operand values biased toward sign, word and shift-amount boundaries
    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return 64'($urandom_range(0, 70));
            5: return 64'h0000_0000_8000_0000 ^ 64'($urandom_range(0, 3));
            6: return {32'hFFFF_FFFF, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic signed [31:0] rand_imm();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            3: return 32'($urandom_range(0, 63));
            4: return 32'($urandom_range(0, 4095)) - 32'sd2048;
            default: return 32'($urandom);
        endcase
    endfunction

    // Mostly implemented codes, some unknown ones; equal operands now and then for branches
    function automatic t_insn rand_insn();
        t_insn x;
        if ($urandom_range(0, 99) < 88) x.func = 7'($urandom_range(0, 71));
        else x.func = 7'($urandom_range(72, 127));
        x.a   = rand_operand();
        x.b   = ($urandom_range(0, 4) == 0) ? x.a : rand_operand();
        x.imm = rand_imm();
        x.pc  = rand_operand();
        x.md  = rand_operand();
        return x;
    endfunction

    // Drive one item and hold it until the unit takes it; leave start high on return
    task automatic send_insn(input t_insn x);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= x.func;
        i_operand_a <= x.a;
        i_operand_b <= x.b;
        i_immediate <= x.imm;
        i_pc        <= x.pc;
        i_mem_data  <= x.md;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start and hold off until every predicted outcome has been checked
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_q.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [6:0] func,
                               input logic [63:0] expv, input logic [63:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch, func %0d: expected %h, actual %h",
                     $time, name, func, expv, actv);
            errors++;
        end
    endtask

    // Check each result against the oldest prediction, then record newly taken items
    always @(posedge i_clk) begin : scoreboard
        t_outcome want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual result %h",
                         $time, o_result);
                errors++;
            end else begin
                want = pending_q.pop_front();
                check_field("result", want.insn.func, want.result, o_result);
                check_field("mem_write_data", want.insn.func, want.wr_data, o_mem_write_data);
                check_field("branch_target", want.insn.func, want.target, o_branch_target);
                check_field("branch_taken", want.insn.func, 64'(want.taken),
                            64'(o_branch_taken));
                check_field("exception", want.insn.func, 64'(want.exc), 64'(o_exception));
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            pending_q.push_back(execute_insn(make_insn(i_func, i_operand_a, i_operand_b,
                                                       i_immediate, i_pc, i_mem_data)));
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One load of each width with its extension rule, and a store passing the source through
    task automatic test_loads_stores();
        send_insn(make_insn(F_LB, '0, '0, 0, 64'h1000, 64'h0123_4567_89AB_CD80));
        send_insn(make_insn(F_LHU, '0, '0, 0, 64'h1004, '1));
        send_insn(make_insn(F_LW, '0, '0, 0, 64'h1008, 64'h0000_0000_8000_0000));
        send_insn(make_insn(F_LD, '0, '0, 0, 64'h100C, '1));
        send_insn(make_insn(F_SD, '1, 64'h55, 32'sh7FFF_FFFF, 64'h1010, '1));
    endtask

    // Shift amounts masked to 6 bits, word shifts to 5 bits with sign extension
    task automatic test_shifts();
        send_insn(make_insn(F_SLLW, 64'd1, 64'd31, 0, '0, '0));
        send_insn(make_insn(F_SRLIW, 64'h0000_0000_8000_0001, '0, 32'shFFFF_FFE0, '0, '0));
        send_insn(make_insn(F_SRA, 64'h8000_0000_0000_0000, '1, 0, '0, '0));
        send_insn(make_insn(F_SRAW, 64'hFFFF_FFFF_8000_0000, 64'd36, 0, '0, '0));
    endtask

    // Wrapping sums, word forms, upper immediates and unsigned compare with a sign-extended negative immediate
    task automatic test_arith();
        send_insn(make_insn(F_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 0, '0, '0));
        send_insn(make_insn(F_ADDIW, 64'd1, '0, 32'sh7FFF_FFFF, '0, '0));
        send_insn(make_insn(F_LUI, '0, '0, 32'sh0008_0000, '0, '0));
        send_insn(make_insn(F_AUIPC, '0, '0, 32'sh000F_FFFF, '1, '0));
        send_insn(make_insn(F_SLTIU, 64'd5, '0, 32'sh8000_0000, '0, '0));
    endtask

    // Signed against unsigned branches, equality, JALR low bit, environment call
    task automatic test_control();
        send_insn(make_insn(F_BLT, '1, 64'd1, -32'sd16, 64'h2000, '0));
        send_insn(make_insn(F_BLTU, '1, 64'd1, -32'sd16, 64'h2000, '0));
        send_insn(make_insn(F_BEQ, 64'h1234, 64'h1234, 32'sh8000_0000, 64'h10, '0));
        send_insn(make_insn(F_JALR, 64'h3001, '0, 32'sd6, '1, '0));
        send_insn(make_insn(F_ECALL, '1, '1, -32'sd1, '1, '1));
    endtask

    // SC success, signed word minimum, unsigned doubleword maximum
    task automatic test_atomics();
        send_insn(make_insn(F_SC, 64'hDEAD_BEEF_0000_0001, '1, 0, '0, '1));
        send_insn(make_insn(F_AMOMIN_W, 64'h0000_0000_0000_0005, '0, 0, '0,
                            64'h1234_5678_FFFF_FFF0));
        send_insn(make_insn(F_AMOMAXU_D, 64'h8000_0000_0000_0000, '0, 0, '0,
                            64'h7FFF_FFFF_FFFF_FFFF));
    endtask

    // Codes past the table raise not-implemented with every other field zero
    task automatic test_unknown_codes();
        send_insn(make_insn(7'd72, '1, '1, -32'sd1, '1, '1));
        send_insn(make_insn(7'd127, '1, '1, -32'sd1, '1, '1));
    endtask

    // Every implemented code once with random operands
    task automatic test_every_code();
        t_insn x;
        for (int code = 0; code <= 71; code++) begin
            x = rand_insn();
            x.func = 7'(code);
            send_insn(x);
        end
    endtask

    // Back-to-back burst, then stop until the pipe has emptied
    task automatic test_drain_pause();
        back_to_back = 1'b1;
        repeat (16) send_insn(rand_insn());
        back_to_back = 1'b0;
        wait_drained();
    endtask

    // Random instructions; some stretches go back-to-back with no gaps
    task automatic test_random();
        for (int i = 0; i < RANDOM_LEN; i++) begin
            if (i % 24 == 0) back_to_back = ($urandom_range(0, 2) == 0);
            send_insn(rand_insn());
        end
        back_to_back = 1'b0;
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_loads_stores();
        test_shifts();
        test_arith();
        test_control();
        test_atomics();
        test_unknown_codes();
        test_every_code();
        test_drain_pause();
        test_random();
        wait_drained();
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
